// ----- rtl/tlbflru_pkg.sv -----
package tlbflru_pkg;

	localparam int PAGE_W    = 20;
	localparam int FRAME_W   = 20;
	localparam int STAMP_W   = 32;
	localparam int KIND_W    = 2;
	localparam int CFG_ENT_W = 5;
	localparam int CFG_W     = 5;
	localparam int CFG_AW    = 1;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

	localparam logic [CFG_AW-1:0] CFG_ENTRIES = 1'd0;
	localparam logic [CFG_AW-1:0] CFG_POLICY  = 1'd1;

	localparam logic [CFG_ENT_W-1:0] ENTRIES_RESET = 5'd16;
	localparam logic                 POLICY_FIFO   = 1'b0;
	localparam logic                 POLICY_LRU    = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame_found;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic lookup;
		logic flush;
		logic remove;
		logic append;
		logic fifo;
		logic lru_init;
		logic lru_step;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              fits;
		logic              lru;
		logic              scan_last;
	} sts_t;

endpackage

// ----- rtl/tlbflru_ctrl.sv -----
module tlbflru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tlbflru_pkg::sts_t   sts,
	output tlbflru_pkg::cmd_t   cmd,
	output logic                busy,
	output logic                done
);
	import tlbflru_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_PLACE = 4'b0100,
		ST_SCAN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				priority if (sts.kind == KIND_INSERT) begin
					cmd.remove = 1'b1;
					state_d    = ST_PLACE;
				end else if (sts.kind == KIND_LOOKUP) begin
					cmd.lookup  = 1'b1;
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else if (sts.kind == KIND_FLUSH) begin
					cmd.flush   = 1'b1;
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_PLACE: begin
				priority if (sts.fits) begin
					cmd.append  = 1'b1;
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else if (sts.lru != POLICY_LRU) begin
					cmd.fifo    = 1'b1;
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.lru_init = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.lru_step = 1'b1;
				if (sts.scan_last) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.respond;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ----- rtl/tlbflru_dp.sv -----
module tlbflru_dp #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlbflru_pkg::cmd_t                   cmd,
	output tlbflru_pkg::sts_t                   sts,
	input  tlbflru_pkg::req_t                   req,
	output tlbflru_pkg::rsp_t                   rsp,
	input  logic                                cfg_we,
	input  logic [tlbflru_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [tlbflru_pkg::CFG_W-1:0]       cfg_wdata
);
	import tlbflru_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CFG_ENT_W) ? CW : CFG_ENT_W;

	logic [PAGE_W-1:0]  page_q  [DEPTH];
	logic [FRAME_W-1:0] frame_q [DEPTH];
	logic [STAMP_W-1:0] stamp_q [DEPTH];

	logic [CW-1:0]        count_q;
	logic [STAMP_W-1:0]   counter_q;
	logic [CFG_ENT_W-1:0] ent_q;
	logic                 policy_q;

	logic [KIND_W-1:0]  kind_q;
	logic [PAGE_W-1:0]  pg_q;
	logic [FRAME_W-1:0] fr_q;
	logic [STAMP_W-1:0] new_stamp_q;
	logic [DEPTH-1:0]   scan_oh_q;
	logic [DEPTH-1:0]   best_oh_q;
	logic [STAMP_W-1:0] best_stamp_q;
	rsp_t               rsp_q;

	logic [DEPTH-1:0]   valid, page_hit, frame_hit, page_first, frame_first;
	logic [DEPTH-1:0]   shift_mask, fifo_mask, tail_oh, append_oh, best_next;
	logic [PAGE_W-1:0]  nxt_page  [DEPTH];
	logic [FRAME_W-1:0] nxt_frame [DEPTH];
	logic [STAMP_W-1:0] nxt_stamp [DEPTH];
	logic [FRAME_W-1:0] frame_out;
	logic [STAMP_W-1:0] scan_stamp, counter_inc;
	logic [LW-1:0]      lim;
	logic               hit, take, scan_last;

	always_comb begin
		frame_out  = '0;
		scan_stamp = '0;
		for (int i = 0; i < DEPTH; i++) begin
			valid[i]     = (count_q > CW'(i));
			page_hit[i]  = valid[i] && (page_q[i] == pg_q);
			frame_hit[i] = valid[i] && (frame_q[i] == fr_q);
			tail_oh[i]   = (count_q == CW'(i + 1));
			append_oh[i] = (count_q == CW'(i));
			fifo_mask[i] = (count_q > CW'(i + 1));
			nxt_page[i]  = page_q[(i + 1) % DEPTH];
			nxt_frame[i] = frame_q[(i + 1) % DEPTH];
			nxt_stamp[i] = stamp_q[(i + 1) % DEPTH];
		end
		page_first  = page_hit & (~page_hit + DEPTH'(1));
		frame_first = frame_hit & (~frame_hit + DEPTH'(1));
		shift_mask  = ~(frame_first - DEPTH'(1));
		for (int i = 0; i < DEPTH; i++) begin
			frame_out  = frame_out | (frame_q[i] & {FRAME_W{page_first[i]}});
			scan_stamp = scan_stamp | (stamp_q[i] & {STAMP_W{scan_oh_q[i]}});
		end
		hit         = |page_first;
		take        = !(best_stamp_q < scan_stamp);
		best_next   = take ? scan_oh_q : best_oh_q;
		scan_last   = |(scan_oh_q & tail_oh);
		counter_inc = (counter_q == '1) ? counter_q : counter_q + STAMP_W'(1);
		if (ent_q == '0) begin
			lim = LW'(1);
		end else if (LW'(ent_q) > LW'(DEPTH)) begin
			lim = LW'(DEPTH);
		end else begin
			lim = LW'(ent_q);
		end
	end

	assign sts.kind      = kind_q;
	assign sts.fits      = (LW'(count_q) < lim);
	assign sts.lru       = policy_q;
	assign sts.scan_last = scan_last;
	assign rsp           = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= req.kind;
			pg_q   <= req.page;
			fr_q   <= req.frame;
		end
		if (cmd.remove) begin
			new_stamp_q <= counter_q;
		end
		if (cmd.lru_init) begin
			scan_oh_q    <= DEPTH'(1);
			best_oh_q    <= DEPTH'(1);
			best_stamp_q <= stamp_q[0];
		end else if (cmd.lru_step) begin
			scan_oh_q    <= scan_oh_q << 1;
			best_oh_q    <= best_next;
			best_stamp_q <= take ? scan_stamp : best_stamp_q;
		end
		if (cmd.respond) begin
			rsp_q.hit         <= cmd.lookup & hit;
			rsp_q.frame_found <= cmd.lookup ? frame_out : '0;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.lookup && page_first[i]) begin
				stamp_q[i] <= counter_q;
			end
			if ((cmd.remove && shift_mask[i]) || (cmd.fifo && fifo_mask[i])) begin
				page_q[i]  <= nxt_page[i];
				frame_q[i] <= nxt_frame[i];
				stamp_q[i] <= nxt_stamp[i];
			end
			if ((cmd.append && append_oh[i]) || (cmd.fifo && tail_oh[i]) ||
			    (cmd.lru_step && scan_last && best_next[i])) begin
				page_q[i]  <= pg_q;
				frame_q[i] <= fr_q;
				stamp_q[i] <= new_stamp_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			counter_q <= '0;
			ent_q     <= ENTRIES_RESET;
			policy_q  <= POLICY_FIFO;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_ENTRIES: ent_q    <= cfg_wdata[CFG_ENT_W-1:0];
					CFG_POLICY:  policy_q <= cfg_wdata[0];
					default:     ent_q    <= ent_q;
				endcase
			end
			if (cmd.flush) begin
				count_q   <= '0;
				counter_q <= '0;
			end else if (cmd.lookup && hit) begin
				counter_q <= counter_inc;
			end else if (cmd.remove) begin
				counter_q <= counter_inc;
				if (|frame_first) begin
					count_q <= count_q - CW'(1);
				end
			end else if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

// ----- rtl/tlb_fifo_lru_replacement_top.sv -----
// Channel  Handshake        Payload            Width
// request  start / busy     req  (kind,page,frame)  42
// result   done             rsp  (hit,frame_found)  21
// config   cfg_we           cfg_addr, cfg_wdata     1, 5
//
// A request is taken when start is high and busy low. Lookup, flush and
// unused kinds end in EXEC; insert goes on through PLACE, and through
// SCAN when LRU replaces (serial stamp scan over the held entries, one
// per cycle). A new request is taken in the cycle done shows.
// Reset clears the fill count and use counter; no clearing pass.
// done is a one-cycle strobe; the receiver cannot stall it.
module tlb_fifo_lru_replacement_top #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tlbflru_pkg::req_t               req,
	output logic                            done,
	output tlbflru_pkg::rsp_t               rsp,
	input  logic                            cfg_we,
	input  logic [tlbflru_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [tlbflru_pkg::CFG_W-1:0]   cfg_wdata
);
	import tlbflru_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tlbflru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tlbflru_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// ----- rtl/tlbflru_checker.sv -----
module tlbflru_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  tlbflru_pkg::rsp_t rsp
);
	import tlbflru_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("transaction ended without a result");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.hit |-> rsp.frame_found == '0)
		else $error("nonzero frame on a miss");

endmodule

bind tlb_fifo_lru_replacement_top tlbflru_checker u_tlbflru_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import tlbflru_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int POOL_N = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	tlb_fifo_lru_replacement_top #(.DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// shadow of the translation buffer
	logic [PAGE_W-1:0] tlb_page [DEPTH];
	logic [FRAME_W-1:0] tlb_frame [DEPTH];
	logic [STAMP_W-1:0] tlb_stamp [DEPTH];
	int tlb_fill = 0;
	logic [STAMP_W-1:0] use_ctr = '0;
	logic [CFG_ENT_W-1:0] cfg_limit = ENTRIES_RESET;
	logic cfg_policy = POLICY_FIFO;

	req_t pending_reqs [$];
	rsp_t rsp_expected [$];
	bit gaps_on = 1'b1;
	int errors = 0;

	logic [PAGE_W-1:0] page_pool [POOL_N];
	logic [FRAME_W-1:0] frame_pool [POOL_N];

	task automatic take_stamp(output logic [STAMP_W-1:0] s);
		s = use_ctr;
		if (use_ctr != '1)
			use_ctr++;
	endtask

	task automatic drop_entry(input int pos);
		for (int i = pos; i + 1 < tlb_fill; i++) begin
			tlb_page[i] = tlb_page[i + 1];
			tlb_frame[i] = tlb_frame[i + 1];
			tlb_stamp[i] = tlb_stamp[i + 1];
		end
		if (tlb_fill > 0)
			tlb_fill--;
	endtask

	task automatic predict_translation(input req_t r);
		rsp_t o;
		logic [STAMP_W-1:0] st;
		int lim;
		int best;
		o = '0;
		case (r.kind)
			KIND_LOOKUP: begin
				for (int i = 0; i < tlb_fill; i++) begin
					if (tlb_page[i] == r.page) begin
						take_stamp(st);
						tlb_stamp[i] = st;
						o.hit = 1'b1;
						o.frame_found = tlb_frame[i];
						break;
					end
				end
			end
			KIND_INSERT: begin
				take_stamp(st);
				for (int i = 0; i < tlb_fill; i++) begin
					if (tlb_frame[i] == r.frame) begin
						drop_entry(i);
						break;
					end
				end
				lim = cfg_limit;
				if (lim < 1)
					lim = 1;
				if (lim > DEPTH)
					lim = DEPTH;
				if (tlb_fill < lim || cfg_policy == POLICY_FIFO) begin
					if (tlb_fill >= lim)
						drop_entry(0);
					tlb_page[tlb_fill] = r.page;
					tlb_frame[tlb_fill] = r.frame;
					tlb_stamp[tlb_fill] = st;
					tlb_fill++;
				end else begin
					best = 0;
					for (int i = 1; i < tlb_fill; i++) begin
						if (!(tlb_stamp[best] < tlb_stamp[i]))
							best = i;
					end
					tlb_page[best] = r.page;
					tlb_frame[best] = r.frame;
					tlb_stamp[best] = st;
				end
			end
			KIND_FLUSH: begin
				tlb_fill = 0;
				use_ctr = '0;
			end
			default: ;
		endcase
		rsp_expected.push_back(o);
	endtask

	// driver: holds start until the transaction is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_ENTRIES: cfg_limit = cfg_wdata[CFG_ENT_W-1:0];
					CFG_POLICY: cfg_policy = cfg_wdata[0];
					default: ;
				endcase
			end
			if (start && !busy)
				predict_translation(req);
			if (!(start && busy)) begin
				if (pending_reqs.size() > 0 && !(gaps_on && $urandom_range(99) < 17)) begin
					req <= pending_reqs.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (rsp_expected.size() == 0) begin
				$error("unexpected result hit=%0d frame_found=%h", rsp.hit, rsp.frame_found);
				errors++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, rsp.hit);
					errors++;
				end
				if (rsp.frame_found !== want.frame_found) begin
					$error("frame_found: expected %h, got %h", want.frame_found,
						rsp.frame_found);
					errors++;
				end
			end
		end
	end

	function automatic req_t mk(logic [KIND_W-1:0] k, logic [PAGE_W-1:0] p,
			logic [FRAME_W-1:0] f);
		req_t r;
		r.kind = k;
		r.page = p;
		r.frame = f;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int sel;
		sel = $urandom_range(99);
		if (sel < 42)
			r.kind = KIND_LOOKUP;
		else if (sel < 86)
			r.kind = KIND_INSERT;
		else if (sel < 89)
			r.kind = KIND_FLUSH;
		else if (sel < 92)
			r.kind = KIND_UNUSED;
		else
			r.kind = KIND_W'($urandom);
		r.page = ($urandom_range(99) < 80) ? page_pool[$urandom_range(POOL_N - 1)]
			: PAGE_W'($urandom);
		r.frame = ($urandom_range(99) < 75) ? frame_pool[$urandom_range(POOL_N - 1)]
			: FRAME_W'($urandom);
		return r;
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || start || rsp_expected.size() > 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] lim, input logic pol, input int n,
			input bit gaps);
		write_reg(CFG_ENTRIES, lim);
		write_reg(CFG_POLICY, {(CFG_W - 1)'($urandom), pol});
		gaps_on = gaps;
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(random_req());
		drain();
	endtask

	initial begin
		#1 arst_n = 1'b0;
		for (int i = 0; i < POOL_N; i++) begin
			page_pool[i] = PAGE_W'($urandom);
			frame_pool[i] = FRAME_W'($urandom);
		end
		page_pool[0] = '0;
		page_pool[1] = '1;
		frame_pool[0] = '0;
		frame_pool[1] = '1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset configuration
		pending_reqs.push_back(mk(KIND_INSERT, '0, '0));
		pending_reqs.push_back(mk(KIND_INSERT, '1, '1));
		pending_reqs.push_back(mk(KIND_LOOKUP, '0, '1));
		pending_reqs.push_back(mk(KIND_LOOKUP, '1, '0));
		pending_reqs.push_back(mk(KIND_LOOKUP, 20'h12345, '0));
		// same frame again: older entry goes away
		pending_reqs.push_back(mk(KIND_INSERT, 20'h00001, '0));
		pending_reqs.push_back(mk(KIND_LOOKUP, '0, '0));
		pending_reqs.push_back(mk(KIND_LOOKUP, 20'h00001, '0));
		// same page again: first match wins
		pending_reqs.push_back(mk(KIND_INSERT, '1, 20'h0aaaa));
		pending_reqs.push_back(mk(KIND_LOOKUP, '1, '0));
		pending_reqs.push_back(mk(KIND_UNUSED, 20'h55555, 20'haaaaa));
		pending_reqs.push_back(mk(KIND_LOOKUP, 20'h00001, '1));
		pending_reqs.push_back(mk(KIND_FLUSH, '1, '1));
		pending_reqs.push_back(mk(KIND_LOOKUP, 20'h00001, '0));
		pending_reqs.push_back(mk(KIND_INSERT, 20'h00005, 20'h00005));
		pending_reqs.push_back(mk(KIND_LOOKUP, 20'h00005, '0));
		drain();

		run_phase(5'd16, POLICY_FIFO, 120, 1'b1);
		run_phase(5'd3, POLICY_LRU, 100, 1'b1);
		run_phase(5'd1, POLICY_LRU, 60, 1'b1);
		run_phase(5'd0, POLICY_FIFO, 60, 1'b1);
		run_phase(5'd31, POLICY_LRU, 120, 1'b0);
		run_phase(5'd16, POLICY_LRU, 120, 1'b1);
		run_phase(5'd5, POLICY_FIFO, 80, 1'b1);
		run_phase(5'd20, POLICY_FIFO, 90, 1'b1);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- tlb_fifo_lru_replacement_top.f -----
rtl/tlbflru_pkg.sv
rtl/tlbflru_ctrl.sv
rtl/tlbflru_dp.sv
rtl/tlb_fifo_lru_replacement_top.sv
rtl/tlbflru_checker.sv
sim/tb.sv
